// ===== rtl/core/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and saturating helpers for the sphere frustum cull.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int REG_COUNT   = 8;
	localparam int CIDX_W      = 3;
	localparam int BASE_PLANES = 6;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
	} coef_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] x,
		input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

endpackage

// ===== rtl/core/sfc_if.sv =====
// ----------------------------------------------------------------------------
// sfc_if
// Channel interfaces: sphere input, cull result, configuration write.
// ----------------------------------------------------------------------------
interface sfc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;
	logic [30:0]        sphere_radius;
	modport source (output valid, center_x, center_y, center_z, sphere_radius,
		input ready);
	modport sink (input valid, center_x, center_y, center_z, sphere_radius,
		output ready);
endinterface

interface sfc_out_if;
	logic valid;
	logic ready;
	logic visible;
	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

interface sfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sfc_plane.sv =====
// ----------------------------------------------------------------------------
// sfc_plane
// One clip plane: distance, squared compare against radius times normal length.
// ----------------------------------------------------------------------------
module sfc_plane
	import sfc_pkg::*;
(
	input  logic               clk,
	input  coef_t              coef,
	input  logic [8:2]         en,
	input  logic signed [31:0] cx_s1,
	input  logic signed [31:0] cy_s1,
	input  logic signed [31:0] cz_s1,
	input  logic [61:0]        rr_s5,
	output logic               rej_s8
);

	coef_t              coef_q;
	logic [63:0]        a2_q, b2_q, c2_q, len_q;
	logic               nz_q;

	logic signed [63:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [63:0] t_s3, p2_s3, p3_s3;
	logic signed [63:0] u_s4, p3_s4;
	logic signed [63:0] dist_s5;
	logic [63:0]        mhh_s6, mhl_s6, mll_s6, rhh_s6, rhl_s6, rlh_s6, rll_s6;
	logic               neg_s6, neg_s7;
	logic [127:0]       dd_s7, rl_s7;
	logic [63:0]        mag;

	assign mag = 64'd0 - dist_s5;

	always_ff @(posedge clk) begin
		coef_q <= coef;
		a2_q   <= 64'(coef_q.a * coef_q.a);
		b2_q   <= 64'(coef_q.b * coef_q.b);
		c2_q   <= 64'(coef_q.c * coef_q.c);
		len_q  <= a2_q + b2_q + c2_q;
		nz_q   <= (coef_q.a != 32'sd0) || (coef_q.b != 32'sd0) || (coef_q.c != 32'sd0);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p0_s2 <= 64'(coef_q.a * cx_s1);
			p1_s2 <= 64'(coef_q.b * cy_s1);
			p2_s2 <= 64'(coef_q.c * cz_s1);
			p3_s2 <= {{16{coef_q.d[31]}}, coef_q.d, 16'd0};
		end
		if (en[3]) begin
			t_s3  <= sat_add64(p0_s2, p1_s2);
			p2_s3 <= p2_s2;
			p3_s3 <= p3_s2;
		end
		if (en[4]) begin
			u_s4  <= sat_add64(t_s3, p2_s3);
			p3_s4 <= p3_s3;
		end
		if (en[5]) begin
			dist_s5 <= sat_add64(u_s4, p3_s4);
		end
		if (en[6]) begin
			neg_s6 <= dist_s5[63];
			mhh_s6 <= mag[63:32] * mag[63:32];
			mhl_s6 <= mag[63:32] * mag[31:0];
			mll_s6 <= mag[31:0] * mag[31:0];
			rhh_s6 <= {2'd0, rr_s5[61:32]} * len_q[63:32];
			rhl_s6 <= {2'd0, rr_s5[61:32]} * len_q[31:0];
			rlh_s6 <= rr_s5[31:0] * len_q[63:32];
			rll_s6 <= rr_s5[31:0] * len_q[31:0];
		end
		if (en[7]) begin
			neg_s7 <= neg_s6;
			dd_s7  <= {mhh_s6, 64'd0} + {31'd0, mhl_s6, 33'd0} + {64'd0, mll_s6};
			rl_s7  <= {rhh_s6, 64'd0} + {32'd0, rhl_s6, 32'd0} + {32'd0, rlh_s6, 32'd0}
				+ {64'd0, rll_s6};
		end
		if (en[8]) begin
			rej_s8 <= neg_s7 && nz_q && (dd_s7 > rl_s7);
		end
	end

endmodule

// ===== rtl/core/sphere_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Bounding sphere versus view frustum test with six matrix-derived planes.
// ----------------------------------------------------------------------------
// Channels: sphere (center_x/y/z, sphere_radius in) and result (visible out),
// valid/ready, transfer when both are high. cfg writes one of eight 64-bit
// matrix registers (two Q16.16 entries each, column-major); always ready.
// Write cfg only while no sphere is in flight, and allow about four cycles
// after the last write before sending spheres (plane and length registers).
// Results are valid at stage s9. Throughput: one sphere per cycle unless the
// pipe is full and stalled; every plane has its own multipliers.
// Each stage holds when its successor is full and stalled, so bubbles close
// up and a result waiting on a stalled receiver does not stop new transfers
// until the pipe is full. sphere.ready follows result.ready combinationally.
// Reset clears the matrix to zero and empties the pipe.
// ----------------------------------------------------------------------------
module sphere_frustum_cull
	import sfc_pkg::*;
#(
	parameter int PLANE_COUNT = 6
) (
	input  logic clk,
	input  logic arst_n,
	sfc_in_if.sink    sphere,
	sfc_out_if.source result,
	sfc_cfg_if.sink   cfg
);

	localparam int NPL = (PLANE_COUNT < BASE_PLANES) ? PLANE_COUNT : BASE_PLANES;

	logic [63:0]        vp_q [REG_COUNT];
	logic [9:1]         v_q;
	logic [10:1]        en;
	logic signed [31:0] cx_s1, cy_s1, cz_s1;
	logic [30:0]        r_s1;
	logic [61:0]        rr_s2, rr_s3, rr_s4, rr_s5;
	logic [NPL-1:0]     rej_s8;
	logic               vis_s9;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REG_COUNT; k++) vp_q[k] <= 64'd0;
		end else if (cfg.valid) begin
			vp_q[cfg.index] <= cfg.data;
		end
	end

	assign en[10] = result.ready;
	always_comb begin
		for (int k = 9; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
	end
	assign sphere.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= sphere.valid;
			for (int k = 2; k <= 9; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cx_s1 <= sphere.center_x;
			cy_s1 <= sphere.center_y;
			cz_s1 <= sphere.center_z;
			r_s1  <= sphere.sphere_radius;
		end
		if (en[2]) rr_s2 <= 62'(r_s1 * r_s1);
		if (en[3]) rr_s3 <= rr_s2;
		if (en[4]) rr_s4 <= rr_s3;
		if (en[5]) rr_s5 <= rr_s4;
		if (en[9]) vis_s9 <= ~|rej_s8;
	end

	for (genvar i = 0; i < NPL; i++) begin : g_plane
		localparam int ROW = i / 2;
		coef_t coef;
		logic signed [31:0] w [4];
		logic signed [31:0] s [4];
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign w[c] = vp_q[c*2+1][63:32];
			assign s[c] = (ROW % 2 == 1) ? vp_q[c*2+ROW/2][63:32] : vp_q[c*2+ROW/2][31:0];
		end
		if (i % 2 == 1) begin : g_minus
			assign coef.a = sat32(33'(w[0]) - 33'(s[0]));
			assign coef.b = sat32(33'(w[1]) - 33'(s[1]));
			assign coef.c = sat32(33'(w[2]) - 33'(s[2]));
			assign coef.d = sat32(33'(w[3]) - 33'(s[3]));
		end else begin : g_plus
			assign coef.a = sat32(33'(w[0]) + 33'(s[0]));
			assign coef.b = sat32(33'(w[1]) + 33'(s[1]));
			assign coef.c = sat32(33'(w[2]) + 33'(s[2]));
			assign coef.d = sat32(33'(w[3]) + 33'(s[3]));
		end
		sfc_plane u_plane (
			.clk    (clk),
			.coef   (coef),
			.en     (en[8:2]),
			.cx_s1  (cx_s1),
			.cy_s1  (cy_s1),
			.cz_s1  (cz_s1),
			.rr_s5  (rr_s5),
			.rej_s8 (rej_s8[i])
		);
	end

	assign result.valid   = v_q[9];
	assign result.visible = vis_s9;

endmodule

// ===== rtl/core/sfc_checker.sv =====
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks for sphere_frustum_cull, bound to the top level.
// ----------------------------------------------------------------------------
module sfc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_visible,
	input logic cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_vis_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_visible))
		else $error("result changed while stalled");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with receiver ready");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sphere.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_visible (result.visible),
	.cfg_ready   (cfg.ready)
);
